FILE: hw/rtl/clec_pkg.sv
`timescale 1ns / 1ps

package clec_pkg;

    localparam int CLEC_QUEUE_DEPTH = 4;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    // Operation codes on the input side.
    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_CURSOR = 3'd2;
    localparam logic [2:0] ACT_CHAR   = 3'd3;
    localparam logic [2:0] ACT_LIGHT  = 3'd4;
    localparam logic [2:0] ACT_GLYPH  = 3'd5;
    localparam logic [2:0] ACT_NACK   = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_SELECT = 2'd1;
    localparam logic [1:0] REG_LIGHT  = 2'd2;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_CURSOR    = 8'h80;
    localparam logic [7:0] CMD_CGRAM     = 8'h40;
    localparam logic [2:0] MAX_ROW       = 3'd3;
    localparam logic [4:0] MAX_COLUMN    = 5'd19;
    localparam logic [15:0] POWER_UP_US  = 16'd60000;
    localparam logic [12:0] NIBBLE_US    = 13'd50;
    localparam logic [12:0] STROBE_US    = 13'd2;
    localparam logic [12:0] CLEAR_US     = 13'd3000;

    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_CLEAR,
        KIND_CURSOR,
        KIND_CHAR,
        KIND_LIGHT,
        KIND_GLYPH
    } clec_kind_t;

    typedef struct packed {
        clec_kind_t  kind;
        logic        light;
        logic [7:0]  cmd;
        logic [63:0] rows;
    } clec_op_t;

    typedef struct packed {
        logic [7:0] enable_mask;
        logic [7:0] select_mask;
        logic [7:0] light_mask;
    } clec_cfg_t;

    typedef struct packed {
        logic [3:0]  nib;
        logic [12:0] extra;
    } clec_nib_t;

    function automatic logic [7:0] clec_row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            default: base = 8'h54;
        endcase
        return base;
    endfunction

    // Power-up sequence: four single nibbles, then four full commands.
    function automatic clec_nib_t clec_init_nibble(input logic [3:0] idx);
        clec_nib_t n;
        case (idx)
            4'd0:    n = '{nib: 4'h3, extra: 13'd5000};
            4'd1:    n = '{nib: 4'h3, extra: 13'd150};
            4'd2:    n = '{nib: 4'h3, extra: 13'd150};
            4'd3:    n = '{nib: 4'h2, extra: 13'd150};
            4'd4:    n = '{nib: 4'h2, extra: 13'd0};
            4'd5:    n = '{nib: 4'h8, extra: 13'd50};
            4'd6:    n = '{nib: 4'h0, extra: 13'd0};
            4'd7:    n = '{nib: 4'hC, extra: 13'd50};
            4'd8:    n = '{nib: 4'h0, extra: 13'd0};
            4'd9:    n = '{nib: 4'h1, extra: 13'd3000};
            4'd10:   n = '{nib: 4'h0, extra: 13'd0};
            default: n = '{nib: 4'h6, extra: 13'd50};
        endcase
        return n;
    endfunction

endpackage

FILE: hw/rtl/clec_front.sv
`timescale 1ns / 1ps

module clec_front
    import clec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [2:0]  action,
    input  logic [2:0]  row,
    input  logic [4:0]  column,
    input  logic [7:0]  char_code,
    input  logic        light_on,
    input  logic [2:0]  glyph_slot,
    input  logic [63:0] glyph_rows,
    input  logic        q_ready,
    output logic        in_ready,
    output logic        push,
    output clec_op_t    op
);

    logic       light_state_reg, light_state_next;
    logic       bus_failed_reg, bus_failed_next;
    logic       accept;
    logic       emit;
    logic [1:0] row_c;
    logic [4:0] col_c;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign row_c    = (row > MAX_ROW) ? MAX_ROW[1:0] : row[1:0];
    assign col_c    = (column > MAX_COLUMN) ? MAX_COLUMN : column;

    always_comb begin
        light_state_next = light_state_reg;
        bus_failed_next  = bus_failed_reg;
        emit             = 1'b0;
        op.kind          = KIND_CLEAR;
        op.cmd           = CMD_CLEAR;
        op.rows          = glyph_rows;
        case (action)
            ACT_INIT: begin
                bus_failed_next = 1'b0;
                emit            = 1'b1;
                op.kind         = KIND_INIT;
            end
            ACT_CLEAR: begin
                emit    = !bus_failed_reg;
                op.kind = KIND_CLEAR;
            end
            ACT_CURSOR: begin
                emit    = !bus_failed_reg;
                op.kind = KIND_CURSOR;
                op.cmd  = CMD_CURSOR | (clec_row_base(row_c) + {3'b000, col_c});
            end
            ACT_CHAR: begin
                emit    = !bus_failed_reg;
                op.kind = KIND_CHAR;
                op.cmd  = char_code;
            end
            ACT_LIGHT: begin
                light_state_next = light_on;
                emit             = !bus_failed_reg;
                op.kind          = KIND_LIGHT;
            end
            ACT_GLYPH: begin
                emit    = !bus_failed_reg;
                op.kind = KIND_GLYPH;
                op.cmd  = CMD_CGRAM | {2'b00, glyph_slot, 3'b000};
            end
            ACT_NACK: begin
                bus_failed_next = 1'b1;
            end
            default: begin
            end
        endcase
        op.light = light_state_next;
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_state_reg <= 1'b1;
            bus_failed_reg  <= 1'b0;
        end else if (accept) begin
            light_state_reg <= light_state_next;
            bus_failed_reg  <= bus_failed_next;
        end
    end

endmodule

FILE: hw/rtl/clec_queue.sv
`timescale 1ns / 1ps

module clec_queue
    import clec_pkg::*;
#(
    parameter int DEPTH = CLEC_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  clec_op_t push_op,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output clec_op_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    clec_op_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

FILE: hw/rtl/clec_back.sv
`timescale 1ns / 1ps

module clec_back
    import clec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  clec_cfg_t   cfg,
    input  logic        q_valid,
    input  clec_op_t    q_head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  expander_byte,
    output logic [15:0] wait_before_us,
    output logic [12:0] wait_after_us,
    output logic        last
);

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_HIGH,
        PH_LOW
    } phase_t;

    logic        busy_reg;
    clec_op_t    op_reg;
    logic [4:0]  idx_reg;
    phase_t      phase_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic [15:0] before_reg;
    logic [12:0] after_reg;
    logic        last_reg;

    logic        adv;
    logic        done_now;
    logic [4:0]  last_idx;
    logic [2:0]  row_sel;
    logic [7:0]  src_byte;
    logic [7:0]  rs;
    logic [3:0]  nib;
    logic [12:0] extra;
    logic [7:0]  b;
    logic [7:0]  raw;
    logic [7:0]  light_or;
    logic [7:0]  byte_next;
    logic [15:0] before_next;
    logic [12:0] after_next;
    clec_nib_t   init_nib;

    assign adv = !out_valid_reg || out_ready;

    always_comb begin
        case (op_reg.kind)
            KIND_INIT:  last_idx = 5'd11;
            KIND_GLYPH: last_idx = 5'd17;
            KIND_LIGHT: last_idx = 5'd0;
            default:    last_idx = 5'd1;
        endcase
    end

    assign row_sel  = 3'(idx_reg[4:1] - 4'd1);
    assign init_nib = clec_init_nibble(idx_reg[3:0]);
    assign light_or = op_reg.light ? cfg.light_mask : 8'h00;

    // Pick the nibble of the current step; full bytes go high nibble first.
    always_comb begin
        src_byte = op_reg.cmd;
        rs       = 8'h00;
        extra    = 13'd0;
        case (op_reg.kind)
            KIND_CHAR: begin
                rs = cfg.select_mask;
            end
            KIND_GLYPH: begin
                if (idx_reg >= 5'd2) begin
                    src_byte = op_reg.rows[row_sel*8 +: 8];
                    rs       = cfg.select_mask;
                end
            end
            KIND_CLEAR: begin
                extra = idx_reg[0] ? CLEAR_US : 13'd0;
            end
            default: begin
            end
        endcase
        nib = idx_reg[0] ? src_byte[3:0] : src_byte[7:4];
        if (op_reg.kind == KIND_INIT) begin
            nib   = init_nib.nib;
            extra = init_nib.extra;
        end
    end

    assign b = {nib, 4'b0000} | rs;

    always_comb begin
        case (phase_reg)
            PH_PLAIN: begin
                raw        = b;
                after_next = 13'd0;
            end
            PH_HIGH: begin
                raw        = b | cfg.enable_mask;
                after_next = STROBE_US;
            end
            default: begin
                raw        = b & ~cfg.enable_mask;
                after_next = NIBBLE_US + extra;
            end
        endcase
        before_next = (op_reg.kind == KIND_INIT && idx_reg == 5'd0 && phase_reg == PH_PLAIN)
                      ? POWER_UP_US : 16'd0;
        byte_next   = raw | light_or;
        done_now    = (phase_reg == PH_LOW) && (idx_reg == last_idx);
        if (op_reg.kind == KIND_LIGHT) begin
            byte_next   = light_or;
            after_next  = 13'd0;
            before_next = 16'd0;
            done_now    = 1'b1;
        end
    end

    assign pop = q_valid && (!busy_reg || (adv && done_now));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= PH_PLAIN;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_valid_reg <= busy_reg;
                byte_reg      <= byte_next;
                before_reg    <= before_next;
                after_reg     <= after_next;
                last_reg      <= done_now;
            end
            if (pop) begin
                busy_reg  <= 1'b1;
                op_reg    <= q_head;
                idx_reg   <= '0;
                phase_reg <= PH_PLAIN;
            end else if (adv && busy_reg) begin
                if (done_now) begin
                    busy_reg <= 1'b0;
                end else begin
                    case (phase_reg)
                        PH_PLAIN: phase_reg <= PH_HIGH;
                        PH_HIGH:  phase_reg <= PH_LOW;
                        default: begin
                            phase_reg <= PH_PLAIN;
                            idx_reg   <= idx_reg + 5'd1;
                        end
                    endcase
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign expander_byte  = byte_reg;
    assign wait_before_us = before_reg;
    assign wait_after_us  = after_reg;
    assign last           = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= last_idx))
        else $error("nibble index ran past the end of the operation");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && op_reg.kind == KIND_LIGHT) |-> (phase_reg == PH_PLAIN))
        else $error("backlight word stepped through strobe phases");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && busy_reg && done_now && !q_valid) |=> !busy_reg)
        else $error("sequencer stayed busy after its final word");

endmodule

FILE: hw/rtl/char_lcd_expander_sequencer.sv
`timescale 1ns / 1ps

// Character-LCD sequencer for a 4-bit display behind an 8-bit I2C port expander.
// Slave stream: one display operation per word; s_tuser holds the operation code
// (init, clear, cursor, char, backlight, glyph, bus NACK), s_tdata its operands.
// Master stream: one expander byte per word with its pause before and after;
// m_tlast marks the final byte of an operation.
// Config channel: cfg_index selects the enable, select or backlight mask
// register; it is always ready and should be written while the block is idle.
// Throughput: one output word per cycle while m_tready is high; an operation has
// 1 byte for backlight, 6 for a command or character, 36 for init and 54 for a
// glyph, set by the single byte sequencer in the back end.
// An operation accepted while the back end is idle goes through the queue and
// op_reg to the output register. Operations queue four deep between front
// and back, so input is taken while the back end is still sending bytes.
// When the receiver stalls, the output word holds and the queue fills; then
// s_tready drops. Reset empties the queue, sets the masks to 0x04, 0x01 and
// 0x08, turns the backlight state on and clears the bus error.
module char_lcd_expander_sequencer
    import clec_pkg::*;
#(
    parameter int QUEUE_DEPTH = CLEC_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row[2:0], column[7:3], char_code[15:8], light_on[16], glyph_slot[19:17],
    // glyph_rows[83:20], zero pad[87:84]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // expander_byte[7:0], wait_before_us[23:8], wait_after_us[36:24],
    // zero pad[39:37]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    clec_cfg_t   cfg_reg;
    clec_op_t    push_op;
    clec_op_t    head;
    logic        push;
    logic        q_not_full;
    logic        q_not_empty;
    logic        pop;
    logic [7:0]  expander_byte;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_mask <= 8'h04;
            cfg_reg.select_mask <= 8'h01;
            cfg_reg.light_mask  <= 8'h08;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLE: cfg_reg.enable_mask <= cfg_data;
                REG_SELECT: cfg_reg.select_mask <= cfg_data;
                REG_LIGHT:  cfg_reg.light_mask  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    clec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .action     (s_tuser),
        .row        (s_tdata[2:0]),
        .column     (s_tdata[7:3]),
        .char_code  (s_tdata[15:8]),
        .light_on   (s_tdata[16]),
        .glyph_slot (s_tdata[19:17]),
        .glyph_rows (s_tdata[83:20]),
        .q_ready    (q_not_full),
        .in_ready   (s_tready),
        .push       (push),
        .op         (push_op)
    );

    clec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (push_op),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    clec_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_not_empty),
        .q_head         (head),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .expander_byte  (expander_byte),
        .wait_before_us (wait_before_us),
        .wait_after_us  (wait_after_us),
        .last           (m_tlast)
    );

    assign m_tdata = {3'b000, wait_after_us, wait_before_us, expander_byte};

endmodule
